// ----- rtl/bhr_pkg.sv -----
// Shared types and constants for the bilinear height-grid resampler.
package bhr_pkg;

  // Field and port widths
  localparam int HEIGHT_W   = 16;
  localparam int COORD_W    = 10;
  localparam int SIZE_W     = 9;
  localparam int STEP_W     = 18;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 18;
  localparam int S_TDATA_W  = 40;

  // Result queue sizing
  localparam int OQ_DEPTH = 4;
  localparam int OQ_PTR_W = $clog2(OQ_DEPTH);
  localparam int OQ_CNT_W = $clog2(OQ_DEPTH + 1);

  // Item kinds
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COLUMN_STEP   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_STEP      = 2'd3;

  localparam logic [SIZE_W-1:0] SOURCE_SIZE_RESET = 9'd256;
  localparam logic [STEP_W-1:0] STEP_RESET        = 18'd65280;

  // Signed height to offset binary and back
  localparam logic [HEIGHT_W-1:0] HEIGHT_OFFSET = 16'h8000;

  // Corner codes: bit 0 selects the ceiling column, bit 1 the ceiling row
  localparam logic [1:0] CORNER_NW = 2'd0;
  localparam logic [1:0] CORNER_NE = 2'd1;
  localparam logic [1:0] CORNER_SW = 2'd2;
  localparam logic [1:0] CORNER_SE = 2'd3;

  typedef struct packed {
    logic                       op;
    logic [COORD_W-1:0]         column;
    logic [COORD_W-1:0]         row_index;
    logic signed [HEIGHT_W-1:0] sample_height;
  } item_t;

  typedef struct packed {
    logic [SIZE_W-1:0] source_width;
    logic [SIZE_W-1:0] source_height;
    logic [STEP_W-1:0] column_step;
    logic [STEP_W-1:0] row_step;
  } cfg_t;

  typedef struct packed {
    logic       valid;
    logic [1:0] corner;
  } corner_tag_t;

endpackage

// ----- rtl/bilinear_heightfield_resampler.sv -----
// Query path: the locate stages, the corner reads of the grid, the blend pipeline and
// the result queue. A query's four corner reads go through the single port of the
// height grid memory; one load per cycle (one write) unless a query's reads hold it.
// Reset (synchronous, active high) clears all valid state, credits and queue
// pointers and restores the config registers; grid contents are not cleared.
// Top level of the bilinear height-grid resampler.
module bilinear_heightfield_resampler import bhr_pkg::*; #(
  parameter int GRID_DIM  = 256,
  parameter int FRAC_BITS = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_write,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [CFG_DATA_W-1:0]      cfg_data,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  input  logic                       s_axis_tuser,   // op
  input  logic [S_TDATA_W-1:0]       s_axis_tdata,   // column, row_index, sample_height
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  output logic signed [HEIGHT_W-1:0] m_axis_tdata    // result_height
);

  localparam int IDX_W = $clog2(GRID_DIM);

  cfg_t                 cfg;
  item_t                in_item;
  logic                 job_valid, job_done, job_op, job_load_ok;
  logic [IDX_W-1:0]     job_x0, job_x1, job_y0, job_y1;
  logic [FRAC_BITS-1:0] job_fx, job_fy, rd_fx, rd_fy;
  logic [HEIGHT_W-1:0]  job_sample, rd_data;
  corner_tag_t          rd_tag;
  logic                 res_valid, out_pop;
  logic signed [HEIGHT_W-1:0] res_height;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.source_width  <= SOURCE_SIZE_RESET;
      cfg.source_height <= SOURCE_SIZE_RESET;
      cfg.column_step   <= STEP_RESET;
      cfg.row_step      <= STEP_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_SOURCE_WIDTH:  cfg.source_width  <= cfg_data[SIZE_W-1:0];
        REG_SOURCE_HEIGHT: cfg.source_height <= cfg_data[SIZE_W-1:0];
        REG_COLUMN_STEP:   cfg.column_step   <= cfg_data[STEP_W-1:0];
        REG_ROW_STEP:      cfg.row_step      <= cfg_data[STEP_W-1:0];
        default:           cfg.row_step      <= cfg.row_step;
      endcase
    end
  end

  // Unpack the input transfer
  always_comb begin
    in_item.op            = s_axis_tuser;
    in_item.column        = s_axis_tdata[COORD_W-1:0];
    in_item.row_index     = s_axis_tdata[2*COORD_W-1:COORD_W];
    in_item.sample_height = s_axis_tdata[2*COORD_W +: HEIGHT_W];
  end

  assign out_pop = m_axis_tvalid && m_axis_tready;

  bhr_locate #(
    .GRID_DIM  (GRID_DIM),
    .FRAC_BITS (FRAC_BITS)
  ) u_locate (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .in_valid    (s_axis_tvalid),
    .in_ready    (s_axis_tready),
    .in_item     (in_item),
    .job_valid   (job_valid),
    .job_done    (job_done),
    .job_op      (job_op),
    .job_load_ok (job_load_ok),
    .job_x0      (job_x0),
    .job_x1      (job_x1),
    .job_y0      (job_y0),
    .job_y1      (job_y1),
    .job_fx      (job_fx),
    .job_fy      (job_fy),
    .job_sample  (job_sample)
  );

  bhr_grid #(
    .GRID_DIM  (GRID_DIM),
    .FRAC_BITS (FRAC_BITS)
  ) u_grid (
    .clk         (clk),
    .rst         (rst),
    .job_valid   (job_valid),
    .job_done    (job_done),
    .job_op      (job_op),
    .job_load_ok (job_load_ok),
    .job_x0      (job_x0),
    .job_x1      (job_x1),
    .job_y0      (job_y0),
    .job_y1      (job_y1),
    .job_fx      (job_fx),
    .job_fy      (job_fy),
    .job_sample  (job_sample),
    .out_pop     (out_pop),
    .rd_tag      (rd_tag),
    .rd_data     (rd_data),
    .rd_fx       (rd_fx),
    .rd_fy       (rd_fy)
  );

  bhr_blend #(
    .FRAC_BITS (FRAC_BITS)
  ) u_blend (
    .clk        (clk),
    .rst        (rst),
    .rd_tag     (rd_tag),
    .rd_data    (rd_data),
    .rd_fx      (rd_fx),
    .rd_fy      (rd_fy),
    .res_valid  (res_valid),
    .res_height (res_height)
  );

  bhr_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (res_valid),
    .push_data (res_height),
    .m_valid   (m_axis_tvalid),
    .m_ready   (m_axis_tready),
    .m_data    (m_axis_tdata)
  );

endmodule

// ----- rtl/bhr_locate.sv -----
// Input stages: source position multiply and floor/ceiling corner location.
module bhr_locate import bhr_pkg::*; #(
  parameter int GRID_DIM  = 256,
  parameter int FRAC_BITS = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  cfg_t                       cfg,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  item_t                      in_item,
  output logic                       job_valid,
  input  logic                       job_done,
  output logic                       job_op,
  output logic                       job_load_ok,
  output logic [$clog2(GRID_DIM)-1:0] job_x0,
  output logic [$clog2(GRID_DIM)-1:0] job_x1,
  output logic [$clog2(GRID_DIM)-1:0] job_y0,
  output logic [$clog2(GRID_DIM)-1:0] job_y1,
  output logic [FRAC_BITS-1:0]       job_fx,
  output logic [FRAC_BITS-1:0]       job_fy,
  output logic [HEIGHT_W-1:0]        job_sample
);

  localparam int IDX_W = $clog2(GRID_DIM);
  localparam int POS_W = COORD_W + STEP_W;
  localparam int LOC_W = IDX_W + FRAC_BITS;

  // Saturate a position to the last column or row of the loaded grid (at least index 1)
  function automatic logic [LOC_W-1:0] locate_axis(input logic [POS_W-1:0] pos,
                                                   input logic [SIZE_W-1:0] size);
    logic [POS_W-1:0]  whole;
    logic [SIZE_W-1:0] last;
    whole = pos >> FRAC_BITS;
    if (size < SIZE_W'(2)) begin
      last = SIZE_W'(1);
    end else if (32'(size) > GRID_DIM) begin
      last = SIZE_W'(GRID_DIM - 1);
    end else begin
      last = size - SIZE_W'(1);
    end
    if (whole >= POS_W'(last)) begin
      locate_axis = {IDX_W'(last), {FRAC_BITS{1'b0}}};
    end else begin
      locate_axis = {IDX_W'(whole), pos[FRAC_BITS-1:0]};
    end
  endfunction

  logic             a_valid, a_free;
  item_t            a_item;
  logic             b_valid, b_free;
  item_t            b_item;
  logic [POS_W-1:0] b_pos_x, b_pos_y;
  logic             c_free;
  logic [LOC_W-1:0] loc_x, loc_y;
  logic [IDX_W-1:0] ix, iy;
  logic [FRAC_BITS-1:0] fx, fy;
  logic             load_ok;

  assign c_free   = !job_valid || job_done;
  assign b_free   = !b_valid || c_free;
  assign a_free   = !a_valid || b_free;
  assign in_ready = a_free;

  // Stage A: hold the accepted item
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (a_free) begin
      a_valid <= in_valid;
    end
    if (in_valid && a_free) begin
      a_item <= in_item;
    end
  end

  // Stage B: scale output coordinates into source positions
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (b_free) begin
      b_valid <= a_valid;
    end
    if (a_valid && b_free) begin
      b_item  <= a_item;
      b_pos_x <= POS_W'(a_item.column) * POS_W'(cfg.column_step);
      b_pos_y <= POS_W'(a_item.row_index) * POS_W'(cfg.row_step);
    end
  end

  // Split positions into index and fraction, check load range
  always_comb begin
    loc_x   = locate_axis(b_pos_x, cfg.source_width);
    loc_y   = locate_axis(b_pos_y, cfg.source_height);
    ix      = loc_x[LOC_W-1:FRAC_BITS];
    iy      = loc_y[LOC_W-1:FRAC_BITS];
    fx      = loc_x[FRAC_BITS-1:0];
    fy      = loc_y[FRAC_BITS-1:0];
    load_ok = (32'(b_item.column) < GRID_DIM) && (32'(b_item.row_index) < GRID_DIM);
  end

  // Stage C: job held until the grid sequencer finishes it
  always_ff @(posedge clk) begin
    if (rst) begin
      job_valid <= 1'b0;
    end else if (c_free) begin
      job_valid <= b_valid;
    end
    if (b_valid && c_free) begin
      job_op      <= b_item.op;
      job_load_ok <= load_ok;
      job_sample  <= b_item.sample_height;
      if (b_item.op == OP_LOAD) begin
        job_x0 <= IDX_W'(b_item.column);
        job_y0 <= IDX_W'(b_item.row_index);
        job_x1 <= IDX_W'(b_item.column);
        job_y1 <= IDX_W'(b_item.row_index);
        job_fx <= '0;
        job_fy <= '0;
      end else begin
        job_x0 <= ix;
        job_y0 <= iy;
        job_x1 <= ix + IDX_W'(fx != '0);
        job_y1 <= iy + IDX_W'(fy != '0);
        job_fx <= fx;
        job_fy <= fy;
      end
    end
  end

endmodule

// ----- rtl/bhr_grid.sv -----
// Height grid memory with the load/corner-read sequencer and result credits.
module bhr_grid import bhr_pkg::*; #(
  parameter int GRID_DIM  = 256,
  parameter int FRAC_BITS = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       job_valid,
  output logic                       job_done,
  input  logic                       job_op,
  input  logic                       job_load_ok,
  input  logic [$clog2(GRID_DIM)-1:0] job_x0,
  input  logic [$clog2(GRID_DIM)-1:0] job_x1,
  input  logic [$clog2(GRID_DIM)-1:0] job_y0,
  input  logic [$clog2(GRID_DIM)-1:0] job_y1,
  input  logic [FRAC_BITS-1:0]       job_fx,
  input  logic [FRAC_BITS-1:0]       job_fy,
  input  logic [HEIGHT_W-1:0]        job_sample,
  input  logic                       out_pop,
  output corner_tag_t                rd_tag,
  output logic [HEIGHT_W-1:0]        rd_data,
  output logic [FRAC_BITS-1:0]       rd_fx,
  output logic [FRAC_BITS-1:0]       rd_fy
);

  localparam int IDX_W  = $clog2(GRID_DIM);
  localparam int DEPTH  = GRID_DIM * GRID_DIM;
  localparam int ADDR_W = $clog2(DEPTH);

  logic [HEIGHT_W-1:0] grid [DEPTH];

  logic [1:0]          beat, beat_next;
  logic [OQ_CNT_W-1:0] credits, credits_next;
  logic                is_query, is_load, credit_ok, go, issue, mem_we;
  logic [IDX_W-1:0]    sel_col, sel_row;
  logic [ADDR_W-1:0]   addr;

  // Sequence one write per in-range load, four corner reads per query
  always_comb begin
    is_load   = job_valid && (job_op == OP_LOAD);
    is_query  = job_valid && (job_op == OP_QUERY);
    credit_ok = credits < OQ_CNT_W'(OQ_DEPTH);
    go        = is_query && ((beat != CORNER_NW) || credit_ok);
    issue     = go && (beat == CORNER_NW);
    mem_we    = is_load && job_load_ok;
    job_done  = is_load || (go && (beat == CORNER_SE));
    beat_next = go ? beat + 2'd1 : beat;
    credits_next = credits + OQ_CNT_W'(issue) - OQ_CNT_W'(out_pop);
    unique case (beat)
      CORNER_NW: begin sel_col = job_x0; sel_row = job_y0; end
      CORNER_NE: begin sel_col = job_x1; sel_row = job_y0; end
      CORNER_SW: begin sel_col = job_x0; sel_row = job_y1; end
      CORNER_SE: begin sel_col = job_x1; sel_row = job_y1; end
      default:   begin sel_col = job_x0; sel_row = job_y0; end
    endcase
    if (is_load) begin
      sel_col = job_x0;
      sel_row = job_y0;
    end
    addr = ADDR_W'(sel_row) * ADDR_W'(GRID_DIM) + ADDR_W'(sel_col);
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      beat          <= CORNER_NW;
      credits       <= '0;
      rd_tag.valid  <= 1'b0;
      rd_tag.corner <= CORNER_NW;
    end else begin
      beat          <= beat_next;
      credits       <= credits_next;
      rd_tag.valid  <= go;
      rd_tag.corner <= beat;
    end
  end

  // Single-port grid: write on load, registered read on query
  always_ff @(posedge clk) begin
    if (mem_we) begin
      grid[addr] <= job_sample;
    end else if (go) begin
      rd_data <= grid[addr];
    end
    rd_fx <= job_fx;
    rd_fy <= job_fy;
  end

`ifndef SYNTHESIS
  a_credit_bound: assert property (@(posedge clk) disable iff (rst)
    credits <= OQ_CNT_W'(OQ_DEPTH))
    else $error("result credits exceed queue depth");

  a_corner_order: assert property (@(posedge clk) disable iff (rst)
    (rd_tag.valid && (rd_tag.corner != CORNER_NW)) |->
      ($past(rd_tag.valid) && (rd_tag.corner == $past(rd_tag.corner) + 2'd1)))
    else $error("corner reads not back to back in order");
`endif

endmodule

// ----- rtl/bhr_blend.sv -----
// Bilinear blend pipeline: column weights, row sums, row weights, rounding.
module bhr_blend import bhr_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  corner_tag_t                rd_tag,
  input  logic [HEIGHT_W-1:0]        rd_data,
  input  logic [FRAC_BITS-1:0]       rd_fx,
  input  logic [FRAC_BITS-1:0]       rd_fy,
  output logic                       res_valid,
  output logic signed [HEIGHT_W-1:0] res_height
);

  localparam int W_W   = FRAC_BITS + 1;
  localparam int P_W   = HEIGHT_W + FRAC_BITS;
  localparam int Q_W   = HEIGHT_W + 2 * FRAC_BITS;
  localparam int SUM_W = Q_W + 1;
  localparam logic [W_W-1:0]   SCALE = W_W'(1) << FRAC_BITS;
  localparam logic [SUM_W-1:0] HALF  = SUM_W'(1) << (2 * FRAC_BITS - 1);

  logic [HEIGHT_W-1:0]  v;
  logic [W_W-1:0]       wx, wy;
  corner_tag_t          s1_tag;
  logic [P_W-1:0]       s1_p, racc;
  logic [FRAC_BITS-1:0] s1_fy, s2_fy;
  logic                 s2_valid, s2_lower;
  logic [P_W-1:0]       s2_row;
  logic                 s3_valid, s3_lower;
  logic [Q_W-1:0]       s3_q, sacc;
  logic [SUM_W-1:0]     sum;

  // Corner weights: ceiling side takes the fraction, floor side the rest
  always_comb begin
    v   = rd_data ^ HEIGHT_OFFSET;
    wx  = rd_tag.corner[0] ? W_W'(rd_fx) : SCALE - W_W'(rd_fx);
    wy  = s2_lower ? W_W'(s2_fy) : SCALE - W_W'(s2_fy);
    sum = SUM_W'(sacc) + SUM_W'(s3_q) + HALF;
  end

  // Valid flags and corner tag
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_tag.valid  <= 1'b0;
      s1_tag.corner <= CORNER_NW;
      s2_valid      <= 1'b0;
      s3_valid      <= 1'b0;
      res_valid     <= 1'b0;
    end else begin
      s1_tag.valid  <= rd_tag.valid;
      s1_tag.corner <= rd_tag.corner;
      s2_valid      <= s1_tag.valid && s1_tag.corner[0];
      s3_valid      <= s2_valid;
      res_valid     <= s3_valid && s3_lower;
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    // weight one corner along the column axis
    s1_p          <= P_W'(v) * P_W'(wx);
    s1_fy         <= rd_fy;
    // add the two corners of a row
    if (s1_tag.valid && !s1_tag.corner[0]) begin
      racc <= s1_p;
    end
    s2_row   <= racc + s1_p;
    s2_lower <= s1_tag.corner[1];
    s2_fy    <= s1_fy;
    // weight the row along the row axis
    s3_q     <= Q_W'(s2_row) * Q_W'(wy);
    s3_lower <= s2_lower;
    // add the rows, round to nearest, remove the offset
    if (s3_valid && !s3_lower) begin
      sacc <= s3_q;
    end
    res_height <= sum[2*FRAC_BITS +: HEIGHT_W] ^ HEIGHT_OFFSET;
  end

endmodule

// ----- rtl/bhr_outq.sv -----
// Result queue that parts the blend pipeline from the output stream.
module bhr_outq import bhr_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  logic signed [HEIGHT_W-1:0] push_data,
  output logic                       m_valid,
  input  logic                       m_ready,
  output logic signed [HEIGHT_W-1:0] m_data
);

  logic [HEIGHT_W-1:0] slots [OQ_DEPTH];
  logic [OQ_PTR_W-1:0] wr_ptr, rd_ptr;
  logic [OQ_CNT_W-1:0] count;
  logic                pop;

  assign m_valid = count != '0;
  assign pop     = m_valid && m_ready;
  assign m_data  = slots[rd_ptr];

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + OQ_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + OQ_PTR_W'(1);
      end
      count <= count + OQ_CNT_W'(push) - OQ_CNT_W'(pop);
    end
  end

  // Store results
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> (count < OQ_CNT_W'(OQ_DEPTH)))
    else $error("result pushed into a full queue");
`endif

endmodule
